/* src/pfe_pkg.sv */
// Shared types and constants for the prime field element ALU.
// Used by pfe_mstep, prime_field_element_alu_unit and pfe_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

   localparam int ELEM_WIDTH = 32;
   localparam int CNT_WIDTH  = $clog2(ELEM_WIDTH);
   localparam logic [ELEM_WIDTH-1:0] MODULUS_RESET = ELEM_WIDTH'(64'd4294967291);

   typedef enum logic [2:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_MUL = 3'd2,
      FUNC_NEG = 3'd3,
      FUNC_INV = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_DISPATCH,
      ST_MUL,
      ST_INV_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]            func;
      logic [ELEM_WIDTH-1:0] operand_a;
      logic [ELEM_WIDTH-1:0] operand_b;
      logic                  last_in;
   } req_type;

   typedef struct packed {
      logic [ELEM_WIDTH-1:0] result;
      logic                  last_out;
   } rsp_type;

endpackage

`default_nettype wire

/* src/pfe_mstep.sv */
// Shared modular step unit: returns (2*acc + addend) mod modulus.
// Depends on pfe_pkg for the element width.
`timescale 1ns / 1ps
`default_nettype none

module pfe_mstep (
   input  wire logic [pfe_pkg::ELEM_WIDTH-1:0] acc,
   input  wire logic [pfe_pkg::ELEM_WIDTH-1:0] addend,
   input  wire logic [pfe_pkg::ELEM_WIDTH-1:0] modulus,
   output logic      [pfe_pkg::ELEM_WIDTH-1:0] step_out
);

   localparam int W = pfe_pkg::ELEM_WIDTH;

   logic [W+1:0] sum;
   logic [W+1:0] mod_1x;
   logic [W+1:0] mod_2x;

   // Both acc and addend are below the modulus, so the sum stays below
   // three times the modulus and one of three candidates is the answer.
   always_comb begin
      sum    = {1'b0, acc, 1'b0} + {2'b00, addend};
      mod_1x = {2'b00, modulus};
      mod_2x = {1'b0, modulus, 1'b0};
      if (sum >= mod_2x) begin
         step_out = W'(sum - mod_2x);
      end else if (sum >= mod_1x) begin
         step_out = W'(sum - mod_1x);
      end else begin
         step_out = sum[W-1:0];
      end
   end

endmodule

`default_nettype wire

/* src/prime_field_element_alu_unit.sv */
// Top level of the prime field element ALU: sequencer, operand registers and output register.
// Depends on pfe_pkg and pfe_mstep.
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_stall  pfe_pkg::req_type
//   rsp_      out         rsp_valid/rsp_stall  pfe_pkg::rsp_type
//   csr_      in          csr_we               csr_wdata (modulus)
//
// Operand a is first reduced by a shift-subtract pass through the one shared
// modular step unit, and operand b too for add, subtract and multiply. Add, subtract
// and negate then finish in the dispatch state, multiply runs a double-and-add step
// per multiplier bit, and invert runs square-and-multiply with exponent modulus - 2.
// An unused function code or a modulus below two goes straight to the finish
// state with a zero result.
// The block takes no item until the previous one has moved into the output
// register; a waiting result holds while rsp_stall is high. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none

module prime_field_element_alu_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire pfe_pkg::req_type           req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output pfe_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_we,
   input  wire logic [pfe_pkg::ELEM_WIDTH-1:0] csr_wdata
);

   localparam int W  = pfe_pkg::ELEM_WIDTH;
   localparam int CW = pfe_pkg::CNT_WIDTH;
   localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

   pfe_pkg::state_type state_ff, state_in;
   logic [W-1:0]  modulus_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   pfe_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [2:0]    func_ff, func_in;
   logic          last_ff, last_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  mr_ff, mr_in;
   logic [W-1:0]  mx_ff, mx_in;
   logic [W-1:0]  my_ff, my_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  base_ff, base_in;
   logic [W-1:0]  exp_ff, exp_in;
   logic          sq_ff, sq_in;
   logic [W-1:0]  res_ff, res_in;

   logic [W-1:0]  step_addend;
   logic [W-1:0]  step_out;
   logic [W:0]    add_sum;
   logic          accept;
   logic          out_free;

   pfe_mstep u_mstep (
      .acc      (mr_ff),
      .addend   (step_addend),
      .modulus  (modulus_ff),
      .step_out (step_out)
   );

   assign req_stall = (state_ff != pfe_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Reduction feeds one operand bit per step; multiply adds x when the
   // current multiplier bit is set.
   always_comb begin
      if (state_ff == pfe_pkg::ST_MUL) begin
         step_addend = my_ff[W-1] ? mx_ff : '0;
      end else begin
         step_addend = {{(W-1){1'b0}}, my_ff[W-1]};
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      func_in      = func_ff;
      last_in      = last_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mr_in        = mr_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      sq_in        = sq_ff;
      res_in       = res_ff;
      add_sum      = {1'b0, a_ff} + {1'b0, b_ff};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pfe_pkg::ST_IDLE: begin
            if (accept) begin
               func_in = req_data.func;
               last_in = req_data.last_in;
               b_in    = req_data.operand_b;
               if (modulus_ff < W'(2) ||
                   !(req_data.func inside {[pfe_pkg::FUNC_ADD:pfe_pkg::FUNC_INV]})) begin
                  res_in   = '0;
                  state_in = pfe_pkg::ST_FINISH;
               end else begin
                  my_in    = req_data.operand_a;
                  mr_in    = '0;
                  cnt_in   = CNT_LAST;
                  state_in = pfe_pkg::ST_RED_A;
               end
            end
         end

         pfe_pkg::ST_RED_A: begin
            mr_in  = step_out;
            my_in  = my_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               a_in = step_out;
               if (func_ff inside {pfe_pkg::FUNC_NEG, pfe_pkg::FUNC_INV}) begin
                  state_in = pfe_pkg::ST_DISPATCH;
               end else begin
                  my_in    = b_ff;
                  mr_in    = '0;
                  cnt_in   = CNT_LAST;
                  state_in = pfe_pkg::ST_RED_B;
               end
            end
         end

         pfe_pkg::ST_RED_B: begin
            mr_in  = step_out;
            my_in  = my_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               b_in     = step_out;
               state_in = pfe_pkg::ST_DISPATCH;
            end
         end

         pfe_pkg::ST_DISPATCH: begin
            state_in = pfe_pkg::ST_FINISH;
            case (func_ff)
               pfe_pkg::FUNC_ADD: begin
                  if (add_sum >= {1'b0, modulus_ff}) begin
                     res_in = W'(add_sum - {1'b0, modulus_ff});
                  end else begin
                     res_in = add_sum[W-1:0];
                  end
               end
               pfe_pkg::FUNC_SUB: begin
                  // A borrow wraps back into range once the modulus is added.
                  if (a_ff >= b_ff) begin
                     res_in = a_ff - b_ff;
                  end else begin
                     res_in = a_ff - b_ff + modulus_ff;
                  end
               end
               pfe_pkg::FUNC_NEG: begin
                  res_in = (a_ff == '0) ? '0 : (modulus_ff - a_ff);
               end
               pfe_pkg::FUNC_MUL: begin
                  mr_in    = '0;
                  mx_in    = a_ff;
                  my_in    = b_ff;
                  cnt_in   = CNT_LAST;
                  sq_in    = 1'b0;
                  state_in = pfe_pkg::ST_MUL;
               end
               pfe_pkg::FUNC_INV: begin
                  acc_in   = W'(1);
                  base_in  = a_ff;
                  exp_in   = modulus_ff - W'(2);
                  state_in = pfe_pkg::ST_INV_CHECK;
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end

         pfe_pkg::ST_MUL: begin
            mr_in  = step_out;
            my_in  = my_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               if (func_ff == pfe_pkg::FUNC_MUL) begin
                  res_in   = step_out;
                  state_in = pfe_pkg::ST_FINISH;
               end else if (!sq_ff) begin
                  // The accumulator multiply is done; square the base next.
                  acc_in = step_out;
                  mr_in  = '0;
                  mx_in  = base_ff;
                  my_in  = base_ff;
                  cnt_in = CNT_LAST;
                  sq_in  = 1'b1;
               end else begin
                  base_in  = step_out;
                  exp_in   = exp_ff >> 1;
                  state_in = pfe_pkg::ST_INV_CHECK;
               end
            end
         end

         pfe_pkg::ST_INV_CHECK: begin
            mr_in  = '0;
            cnt_in = CNT_LAST;
            my_in  = base_ff;
            if (exp_ff == '0) begin
               res_in   = acc_ff;
               state_in = pfe_pkg::ST_FINISH;
            end else if (exp_ff[0]) begin
               mx_in    = acc_ff;
               sq_in    = 1'b0;
               state_in = pfe_pkg::ST_MUL;
            end else begin
               mx_in    = base_ff;
               sq_in    = 1'b1;
               state_in = pfe_pkg::ST_MUL;
            end
         end

         pfe_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.result   = res_ff;
               rsp_data_in.last_out = last_ff;
               state_in             = pfe_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pfe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= pfe_pkg::MODULUS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            modulus_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      func_ff     <= func_in;
      last_ff     <= last_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      mr_ff       <= mr_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      sq_ff       <= sq_in;
      res_ff      <= res_in;
   end

endmodule

`default_nettype wire

/* src/pfe_checker.sv */
// Port-level checks for prime_field_element_alu_unit, bound to the top level.
// Depends on pfe_pkg and prime_field_element_alu_unit.
`timescale 1ns / 1ps
`default_nettype none

module pfe_port_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire pfe_pkg::req_type               req_data,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire pfe_pkg::rsp_type               rsp_data,
   input wire logic                           csr_we,
   input wire logic [pfe_pkg::ELEM_WIDTH-1:0] csr_wdata
);

   // A stalled result holds its place and its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or dropped");

   // Once an item is taken, the block stays busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after an accepted item");

   // A new result only appears at the end of work, while the input side is busy.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result item appeared without an item in progress");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind prime_field_element_alu_unit pfe_port_checker u_pfe_port_checker (.*);

`default_nettype wire
